FILE: design/variable_length_bit_packer_core_defines.svh
// assertion macros for the bit packer checker
`ifndef VARIABLE_LENGTH_BIT_PACKER_CORE_DEFINES_SVH
`define VARIABLE_LENGTH_BIT_PACKER_CORE_DEFINES_SVH

// clocked check, off while reset is asserted
`define VLBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define VLBP_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vlbp_pkg.sv
// shared types and constants of the bit packer
package vlbp_pkg;

	localparam int CODE_W = 16;
	localparam int CNT_W  = 5;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 3;

	typedef struct packed {
		logic [CODE_W-1:0] code_value;
		logic [CNT_W-1:0]  bit_count;
		logic              msb_first;
	} src_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              last_byte;
	} dst_req_t;

endpackage

FILE: design/vlbp_front.sv
// front end: takes requests, aligns code bits and merges them into the partial byte
module vlbp_front #(
	parameter int MAX_CODE_BITS = 16,
	parameter int DATA_W        = 16,
	parameter int NB_W          = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  vlbp_pkg::src_req_t     src_data,
	input  logic                   full,
	output logic                   push,
	output logic [DATA_W-1:0]      push_data,
	output logic [NB_W-1:0]        push_nbytes
);
	import vlbp_pkg::*;

	localparam int CNT_S_W = $clog2(MAX_CODE_BITS + 1);
	localparam int ACC_W   = MAX_CODE_BITS + BYTE_W - 1;
	localparam int TOT_W   = $clog2(MAX_CODE_BITS + BYTE_W);

	logic [CODE_W+MAX_CODE_BITS-1:0] code_wide;
	logic [MAX_CODE_BITS-1:0]        code_ext;
	logic [MAX_CODE_BITS-1:0]        code_rev;
	logic [MAX_CODE_BITS-1:0]        word;
	logic [CNT_S_W-1:0]              cnt;
	logic                            accept;
	logic                            advance;

	logic                            v_s1;
	logic [MAX_CODE_BITS-1:0]        w_s1;
	logic [CNT_S_W-1:0]              cnt_s1;

	logic [BYTE_W-1:0]               pending_q;
	logic [POS_W-1:0]                pos_q;

	logic [ACC_W-1:0]                acc;
	logic [TOT_W-1:0]                total;
	logic [TOT_W-POS_W-1:0]          nbytes;
	logic [BYTE_W-1:0]               next_pending;

	// stage 1: saturate count, pick bit order, drop uncounted bits
	always_comb begin
		code_wide = {{MAX_CODE_BITS{1'b0}}, src_data.code_value};
		code_ext  = code_wide[MAX_CODE_BITS-1:0];
		for (int j = 0; j < MAX_CODE_BITS; j++) begin
			code_rev[j] = code_ext[MAX_CODE_BITS-1-j];
		end
		if (int'(src_data.bit_count) > MAX_CODE_BITS) begin
			cnt = CNT_S_W'(MAX_CODE_BITS);
		end else begin
			cnt = CNT_S_W'(src_data.bit_count);
		end
		if (src_data.msb_first) begin
			word = code_rev >> (CNT_S_W'(MAX_CODE_BITS) - cnt);
		end else begin
			word = code_ext & ~({MAX_CODE_BITS{1'b1}} << cnt);
		end
	end

	assign advance   = !full;
	assign src_stall = v_s1 && !advance;
	assign accept    = src_valid && !src_stall;

	// stage 2: merge into the partial byte, completed bytes go to the queue
	always_comb begin
		acc          = ACC_W'(pending_q) | (ACC_W'(w_s1) << pos_q);
		total        = TOT_W'(pos_q) + TOT_W'(cnt_s1);
		nbytes       = total[TOT_W-1:POS_W];
		next_pending = BYTE_W'(acc >> {nbytes, {POS_W{1'b0}}});
	end

	assign push        = v_s1 && advance && (nbytes != '0);
	assign push_data   = acc[DATA_W-1:0];
	assign push_nbytes = NB_W'(nbytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			pending_q <= '0;
			pos_q     <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && advance) begin
				pending_q <= next_pending;
				pos_q     <= total[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1   <= word;
			cnt_s1 <= cnt;
		end
	end

endmodule

FILE: design/vlbp_fifo.sv
// two-entry queue of completed byte groups between front and back
module vlbp_fifo #(
	parameter int DATA_W = 16,
	parameter int NB_W   = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic [NB_W-1:0]   push_nbytes,
	input  logic              pop,
	output logic              full,
	output logic              nonempty,
	output logic [DATA_W-1:0] head_data,
	output logic [NB_W-1:0]   head_nbytes
);
	import vlbp_pkg::*;

	localparam int DEPTH = 2;

	logic [DATA_W-1:0] data_q [DEPTH];
	logic [NB_W-1:0]   nb_q   [DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full        = (count_q == 2'(DEPTH));
	assign nonempty    = (count_q != '0);
	assign head_data   = data_q[rd_ptr_q];
	assign head_nbytes = nb_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
			nb_q[wr_ptr_q]   <= push_nbytes;
		end
	end

endmodule

FILE: design/vlbp_back.sv
// back end: sends the bytes of each queued group one request at a time
module vlbp_back #(
	parameter int DATA_W = 16,
	parameter int NB_W   = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nonempty,
	input  logic [DATA_W-1:0]  head_data,
	input  logic [NB_W-1:0]    head_nbytes,
	output logic               pop,
	output logic               dst_valid,
	input  logic               dst_stall,
	output vlbp_pkg::dst_req_t dst_data
);
	import vlbp_pkg::*;

	logic              busy_q;
	logic [DATA_W-1:0] data_q;
	logic [NB_W-1:0]   left_q;
	logic              out_accept;
	logic              last;

	assign last       = (left_q == NB_W'(1));
	assign out_accept = busy_q && !dst_stall;
	// reload when empty or when the final byte of a group leaves
	assign pop        = nonempty && (!busy_q || (out_accept && last));

	assign dst_valid            = busy_q;
	assign dst_data.packed_byte = data_q[BYTE_W-1:0];
	assign dst_data.last_byte   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				left_q <= head_nbytes;
			end else if (out_accept) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				left_q <= left_q - NB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head_data;
		end else if (out_accept) begin
			data_q <= data_q >> BYTE_W;
		end
	end

endmodule

FILE: design/variable_length_bit_packer_core.sv
// LSB-first bit packer: codes of up to MAX_CODE_BITS bits go in, completed bytes come
// out, earliest bit in bit 0. A request is taken every cycle while the two-entry queue
// of byte groups has room; the result side sends one byte per cycle while dst_stall is
// low. An item that completes no byte queues nothing; one item completes up to two
// bytes at the default width. The partial byte is kept and never flushed.
module variable_length_bit_packer_core #(
	parameter int MAX_CODE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  vlbp_pkg::src_req_t src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output vlbp_pkg::dst_req_t dst_data
);
	import vlbp_pkg::*;

	localparam int NB     = (MAX_CODE_BITS + BYTE_W - 1) / BYTE_W;
	localparam int DATA_W = NB * BYTE_W;
	localparam int NB_W   = $clog2(NB + 1);

	logic              full;
	logic              push;
	logic [DATA_W-1:0] push_data;
	logic [NB_W-1:0]   push_nbytes;
	logic              pop;
	logic              nonempty;
	logic [DATA_W-1:0] head_data;
	logic [NB_W-1:0]   head_nbytes;

	vlbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.DATA_W       (DATA_W),
		.NB_W         (NB_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_data   (src_data),
		.full       (full),
		.push       (push),
		.push_data  (push_data),
		.push_nbytes(push_nbytes)
	);

	vlbp_fifo #(
		.DATA_W(DATA_W),
		.NB_W  (NB_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_nbytes(push_nbytes),
		.pop        (pop),
		.full       (full),
		.nonempty   (nonempty),
		.head_data  (head_data),
		.head_nbytes(head_nbytes)
	);

	vlbp_back #(
		.DATA_W(DATA_W),
		.NB_W  (NB_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (nonempty),
		.head_data  (head_data),
		.head_nbytes(head_nbytes),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_data   (dst_data)
	);

endmodule

FILE: design/vlbp_checker.sv
// port-level checks of the bit packer, bound to the top level
`include "variable_length_bit_packer_core_defines.svh"

module vlbp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input vlbp_pkg::src_req_t src_data,
	input logic               dst_valid,
	input logic               dst_stall,
	input vlbp_pkg::dst_req_t dst_data
);
	import vlbp_pkg::*;

	`VLBP_ASSERT(a_dst_hold, dst_valid && dst_stall |=> dst_valid && $stable(dst_data), "stalled result changed")
	// reset clears the result side
	`VLBP_ASSERT_RST(a_rst_quiet, !arst_n |=> !dst_valid, "result offered during reset")
	// bytes of one group leave back to back
	`VLBP_ASSERT(a_group_cont, dst_valid && !dst_stall && !dst_data.last_byte |=> dst_valid, "gap inside byte group")

endmodule

bind variable_length_bit_packer_core vlbp_checker u_vlbp_checker (.*);
